@@ rtl/fs_pkg.sv @@
// ----------------------------------------------------------------------------
// fs_pkg
// Shared widths, codes, state encoding and the request bundle of the serial
// modular multiplier used by the Fermat sketch block.
// ----------------------------------------------------------------------------
`default_nettype none

package fs_pkg;

	localparam int P_W        = 31;
	localparam int CNT_W      = 32;
	localparam int IDX_W      = 5;
	localparam int SLOT_W     = 7;
	localparam int SLOTS      = 128;
	localparam int ENTRY_W    = CNT_W + P_W;
	localparam int ROW_DEPTH_DEF = 16;
	localparam int HASH_OFFSET   = 2;
	localparam int MM_STEPS_W    = 5;

	localparam logic [P_W-1:0] PRIME_RESET = 31'h7FFF_FFFF;
	localparam logic [P_W-1:0] PRIME_MIN   = 31'd3;

	typedef enum logic [1:0] {
		OP_INS_A  = 2'd0,
		OP_INS_B  = 2'd1,
		OP_DECODE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_KEY,
		S_HASH,
		S_HMOD,
		S_IRD,
		S_IWAIT,
		S_IRED,
		S_DRD_A,
		S_DRD_B,
		S_DCMP,
		S_DIA,
		S_DIB,
		S_DM,
		S_PSTEP,
		S_PMW,
		S_PSQ,
		S_PFIN,
		S_EMIT,
		S_NEXT,
		S_MARK
	} state_t;

	typedef struct packed {
		logic             start;
		logic [P_W-1:0]   a;
		logic [CNT_W-1:0] b;
		logic [P_W-1:0]   m;
	} mm_req_t;

	typedef struct packed {
		logic           done;
		logic [P_W-1:0] res;
	} mm_rsp_t;

endpackage

`default_nettype wire

@@ rtl/fs_ram.sv @@
// ----------------------------------------------------------------------------
// fs_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/fs_modmul.sv @@
// ----------------------------------------------------------------------------
// fs_modmul
// Bit-serial modular multiplier: computes (a * b) mod m one bit of b per
// cycle, most significant bit first. Requires a <= m.
// ----------------------------------------------------------------------------
`default_nettype none

module fs_modmul (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire fs_pkg::mm_req_t req,
	output fs_pkg::mm_rsp_t      rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic [fs_pkg::MM_STEPS_W-1:0] cnt_q;
	logic [fs_pkg::P_W-1:0]        r_q;
	logic [fs_pkg::P_W-1:0]        a_q;
	logic [fs_pkg::P_W-1:0]        m_q;
	logic [fs_pkg::CNT_W-1:0]      b_q;
	logic [fs_pkg::CNT_W-1:0]      dbl;
	logic [fs_pkg::CNT_W-1:0]      sum;
	logic [fs_pkg::CNT_W-1:0]      mext;

	always_comb begin
		mext = {1'b0, m_q};
		dbl  = {r_q, 1'b0};
		if (dbl >= mext) begin
			dbl = dbl - mext;
		end
		sum = dbl + (b_q[fs_pkg::CNT_W-1] ? {1'b0, a_q} : '0);
		if (sum >= mext) begin
			sum = sum - mext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q <= '0;
			a_q <= req.a;
			b_q <= req.b;
			m_q <= req.m;
		end else if (busy_q) begin
			r_q <= sum[fs_pkg::P_W-1:0];
			b_q <= {b_q[fs_pkg::CNT_W-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = r_q;

endmodule

`default_nettype wire

@@ rtl/fermat_sketch_insert_decode.sv @@
// ----------------------------------------------------------------------------
// fermat_sketch_insert_decode
// Two Fermat sketches held in one bucket memory, with insert and decode of
// the difference between them.
// ----------------------------------------------------------------------------
// Usage: input transfers carry the operation in s_tuser and the key in
// s_tdata. The block takes one item at a time; s_tready is high only while
// it is idle. An insert reduces the key modulo the prime on the bit-serial
// multiplier, hashes it and does a read-modify-write of one bucket in each
// row; it produces no output. A decode walks both rows, and each bucket whose
// count difference is nonzero gives one output transfer; a marker transfer
// with m_tlast ends the run. Results go through one output register, so the
// block keeps working while a result waits, and only stalls when a second
// result is ready before the first is taken. Reset clears the valid bit of
// every bucket, so all buckets read as zero, and sets the modulus to
// 2^31 - 1.
// ----------------------------------------------------------------------------
`default_nettype none

module fermat_sketch_insert_decode #(
	parameter int ROW_DEPTH = fs_pkg::ROW_DEPTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [31:0]  s_tdata,   // key[30:0], zero fill
	input  wire logic [1:0]   s_tuser,   // operation[1:0]
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [103:0]      m_tdata,   // row_number, bucket_index[4:0],
	                                     // count_difference[31:0],
	                                     // id_difference[30:0],
	                                     // recovered_key[30:0], zero fill
	output logic              m_tuser,   // is_marker
	output logic              m_tlast,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int P_W   = fs_pkg::P_W;
	localparam int CNT_W = fs_pkg::CNT_W;
	localparam int IDX_W = fs_pkg::IDX_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROW_DEPTH - 1);
	localparam logic [P_W-1:0]   DEPTH_M  = P_W'(ROW_DEPTH);
	localparam int HASH_SH = P_W + $clog2(ROW_DEPTH);
	localparam logic [CNT_W-1:0] HASH_RECIP =
		CNT_W'((64'd1 << HASH_SH) / 64'(ROW_DEPTH) + 64'd1);

	fs_pkg::state_t  state_q, state_d;
	fs_pkg::mm_req_t mm_req;
	fs_pkg::mm_rsp_t mm_rsp;

	logic [P_W-1:0]   prime_q;
	logic [P_W-1:0]   p_eff;
	logic [1:0]       op_q;
	logic [P_W-1:0]   k_q;
	logic [IDX_W-1:0] h0_q;
	logic [IDX_W-1:0] h1;
	logic [IDX_W+1:0] h1_t;
	logic [P_W+CNT_W-1:0] hash_prod;
	logic [P_W-1:0]   quo_q;
	logic [P_W-1:0]   hash_rem;
	logic             row_q;
	logic [IDX_W-1:0] idx_q;
	logic [fs_pkg::SLOT_W-1:0] raddr, waddr_q;
	logic [fs_pkg::ENTRY_W-1:0] rdata_raw, rdata, wdata;
	logic             we;
	logic [fs_pkg::SLOTS-1:0] vld_q;
	logic             rvld_q;
	logic [CNT_W-1:0] cnt_raw_q;
	logic [CNT_W-1:0] ca_q;
	logic [P_W-1:0]   ida_q, idb_q;
	logic [CNT_W-1:0] cd_q;
	logic [CNT_W-1:0] cd_now;
	logic [CNT_W-1:0] mag;
	logic [P_W-1:0]   ia_q, idd_q, m_q, base_q, acc_q;
	logic [P_W-1:0]   e_q;
	logic [P_W-1:0]   rk_q;
	logic [P_W:0]     id_sum;
	logic [P_W:0]     idd_t;
	logic             out_free;
	logic             load_rec, load_mark;
	logic             cfg_we;

	logic             ov_q;
	logic             o_mark_q;
	logic             o_row_q;
	logic [IDX_W-1:0] o_idx_q;
	logic [CNT_W-1:0] o_cd_q;
	logic [P_W-1:0]   o_idd_q, o_rk_q;

	// Configuration.
	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite & ~paddr[2];
	assign prdata = paddr[2] ? 32'd0 : {1'b0, prime_q};
	assign p_eff  = (prime_q < fs_pkg::PRIME_MIN) ? fs_pkg::PRIME_MIN : prime_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_q <= fs_pkg::PRIME_RESET;
		end else if (cfg_we) begin
			prime_q <= pwdata[P_W-1:0];
		end
	end

	// Bucket memory with per-entry valid bits.
	fs_ram #(
		.WIDTH(fs_pkg::ENTRY_W),
		.DEPTH(fs_pkg::SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr_q),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			rvld_q <= vld_q[raddr];
			if (we) begin
				vld_q[waddr_q] <= 1'b1;
			end
		end
	end

	assign rdata = rvld_q ? rdata_raw : '0;

	fs_modmul u_mm (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mm_req),
		.rsp   (mm_rsp)
	);

	// First hash: the quotient by ROW_DEPTH comes from a scaled reciprocal.
	assign hash_prod = k_q * HASH_RECIP;
	assign hash_rem  = k_q - P_W'(quo_q * DEPTH_M);

	// Second hash: (h0 + 2) mod ROW_DEPTH with h0 below ROW_DEPTH.
	always_comb begin
		h1_t = (IDX_W+2)'(h0_q) + (IDX_W+2)'(fs_pkg::HASH_OFFSET);
		if (h1_t >= (IDX_W+2)'(ROW_DEPTH)) begin
			h1_t = h1_t - (IDX_W+2)'(ROW_DEPTH);
		end
		if (h1_t >= (IDX_W+2)'(ROW_DEPTH)) begin
			h1_t = h1_t - (IDX_W+2)'(ROW_DEPTH);
		end
		h1 = h1_t[IDX_W-1:0];
	end

	assign cd_now = ca_q - rdata[fs_pkg::ENTRY_W-1:P_W];
	assign mag    = cd_q[CNT_W-1] ? (CNT_W'(0) - cd_q) : cd_q;
	assign id_sum = {1'b0, mm_rsp.res} + {1'b0, k_q};
	assign wdata  = {cnt_raw_q + 1'b1,
		(id_sum >= {1'b0, p_eff}) ? P_W'(id_sum - {1'b0, p_eff}) : id_sum[P_W-1:0]};
	assign idd_t  = {1'b0, ia_q} - {1'b0, mm_rsp.res};
	assign out_free = ~ov_q | m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mm_req    = '0;
		raddr     = '0;
		we        = 1'b0;
		load_rec  = 1'b0;
		load_mark = 1'b0;
		s_tready  = 1'b0;
		unique case (state_q)
			fs_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (s_tuser)
						fs_pkg::OP_INS_A, fs_pkg::OP_INS_B: begin
							mm_req = '{1'b1, P_W'(1), {1'b0, s_tdata[P_W-1:0]}, p_eff};
							state_d = fs_pkg::S_KEY;
						end
						fs_pkg::OP_DECODE: state_d = fs_pkg::S_DRD_A;
						default: state_d = fs_pkg::S_IDLE;
					endcase
				end
			end
			fs_pkg::S_KEY: begin
				if (mm_rsp.done) begin
					state_d = fs_pkg::S_HASH;
				end
			end
			fs_pkg::S_HASH: begin
				state_d = fs_pkg::S_HMOD;
			end
			fs_pkg::S_HMOD: begin
				state_d = fs_pkg::S_IRD;
			end
			fs_pkg::S_IRD: begin
				raddr = {op_q[0], row_q, row_q ? h1 : h0_q};
				state_d = fs_pkg::S_IWAIT;
			end
			fs_pkg::S_IWAIT: begin
				mm_req = '{1'b1, P_W'(1), {1'b0, rdata[P_W-1:0]}, p_eff};
				state_d = fs_pkg::S_IRED;
			end
			fs_pkg::S_IRED: begin
				if (mm_rsp.done) begin
					we = 1'b1;
					state_d = row_q ? fs_pkg::S_IDLE : fs_pkg::S_IRD;
				end
			end
			fs_pkg::S_DRD_A: begin
				raddr = {1'b0, row_q, idx_q};
				state_d = fs_pkg::S_DRD_B;
			end
			fs_pkg::S_DRD_B: begin
				raddr = {1'b1, row_q, idx_q};
				state_d = fs_pkg::S_DCMP;
			end
			fs_pkg::S_DCMP: begin
				if (cd_now == '0) begin
					state_d = fs_pkg::S_NEXT;
				end else begin
					mm_req = '{1'b1, P_W'(1), {1'b0, ida_q}, p_eff};
					state_d = fs_pkg::S_DIA;
				end
			end
			fs_pkg::S_DIA: begin
				if (mm_rsp.done) begin
					mm_req = '{1'b1, P_W'(1), {1'b0, idb_q}, p_eff};
					state_d = fs_pkg::S_DIB;
				end
			end
			fs_pkg::S_DIB: begin
				if (mm_rsp.done) begin
					mm_req = '{1'b1, P_W'(1), mag, p_eff};
					state_d = fs_pkg::S_DM;
				end
			end
			fs_pkg::S_DM: begin
				if (mm_rsp.done) begin
					state_d = fs_pkg::S_PSTEP;
				end
			end
			fs_pkg::S_PSTEP: begin
				if (e_q[0]) begin
					mm_req = '{1'b1, acc_q, {1'b0, base_q}, p_eff};
					state_d = fs_pkg::S_PMW;
				end else begin
					mm_req = '{1'b1, base_q, {1'b0, base_q}, p_eff};
					state_d = fs_pkg::S_PSQ;
				end
			end
			fs_pkg::S_PMW: begin
				if (mm_rsp.done) begin
					mm_req = '{1'b1, base_q, {1'b0, base_q}, p_eff};
					state_d = fs_pkg::S_PSQ;
				end
			end
			fs_pkg::S_PSQ: begin
				if (mm_rsp.done) begin
					if (e_q[P_W-1:1] == '0) begin
						mm_req = '{1'b1, idd_q, {1'b0, acc_q}, p_eff};
						state_d = fs_pkg::S_PFIN;
					end else begin
						state_d = fs_pkg::S_PSTEP;
					end
				end
			end
			fs_pkg::S_PFIN: begin
				if (mm_rsp.done) begin
					state_d = fs_pkg::S_EMIT;
				end
			end
			fs_pkg::S_EMIT: begin
				if (out_free) begin
					load_rec = 1'b1;
					state_d = fs_pkg::S_NEXT;
				end
			end
			fs_pkg::S_NEXT: begin
				if (idx_q == LAST_IDX && row_q) begin
					state_d = fs_pkg::S_MARK;
				end else begin
					state_d = fs_pkg::S_DRD_A;
				end
			end
			fs_pkg::S_MARK: begin
				if (out_free) begin
					load_mark = 1'b1;
					state_d = fs_pkg::S_IDLE;
				end
			end
			default: state_d = fs_pkg::S_IDLE;
		endcase
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			fs_pkg::S_IDLE: begin
				op_q  <= s_tuser;
				row_q <= 1'b0;
				idx_q <= '0;
			end
			fs_pkg::S_KEY: begin
				if (mm_rsp.done) begin
					k_q <= mm_rsp.res;
				end
			end
			fs_pkg::S_HASH: begin
				quo_q <= P_W'(hash_prod >> HASH_SH);
			end
			fs_pkg::S_HMOD: begin
				h0_q <= hash_rem[IDX_W-1:0];
			end
			fs_pkg::S_IRD: begin
				waddr_q <= raddr;
			end
			fs_pkg::S_IWAIT: begin
				cnt_raw_q <= rdata[fs_pkg::ENTRY_W-1:P_W];
			end
			fs_pkg::S_IRED: begin
				if (mm_rsp.done) begin
					row_q <= 1'b1;
				end
			end
			fs_pkg::S_DRD_B: begin
				ca_q  <= rdata[fs_pkg::ENTRY_W-1:P_W];
				ida_q <= rdata[P_W-1:0];
			end
			fs_pkg::S_DCMP: begin
				cd_q  <= cd_now;
				idb_q <= rdata[P_W-1:0];
			end
			fs_pkg::S_DIA: begin
				if (mm_rsp.done) begin
					ia_q <= mm_rsp.res;
				end
			end
			fs_pkg::S_DIB: begin
				if (mm_rsp.done) begin
					idd_q <= idd_t[P_W] ? P_W'(idd_t + {1'b0, p_eff}) : idd_t[P_W-1:0];
				end
			end
			fs_pkg::S_DM: begin
				if (mm_rsp.done) begin
					if (cd_q[CNT_W-1] && mm_rsp.res != '0) begin
						m_q    <= p_eff - mm_rsp.res;
						base_q <= p_eff - mm_rsp.res;
					end else begin
						m_q    <= mm_rsp.res;
						base_q <= mm_rsp.res;
					end
					acc_q <= P_W'(1);
					e_q   <= p_eff - P_W'(2);
				end
			end
			fs_pkg::S_PMW: begin
				if (mm_rsp.done) begin
					acc_q <= mm_rsp.res;
				end
			end
			fs_pkg::S_PSQ: begin
				if (mm_rsp.done) begin
					base_q <= mm_rsp.res;
					e_q    <= e_q >> 1;
				end
			end
			fs_pkg::S_PFIN: begin
				if (mm_rsp.done) begin
					rk_q <= (m_q == '0) ? '0 : mm_rsp.res;
				end
			end
			fs_pkg::S_NEXT: begin
				if (idx_q == LAST_IDX) begin
					idx_q <= '0;
					row_q <= 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (load_rec || load_mark) begin
			ov_q <= 1'b1;
		end else if (m_tready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rec) begin
			o_mark_q <= 1'b0;
			o_row_q  <= row_q;
			o_idx_q  <= idx_q;
			o_cd_q   <= cd_q;
			o_idd_q  <= idd_q;
			o_rk_q   <= rk_q;
		end else if (load_mark) begin
			o_mark_q <= 1'b1;
			o_row_q  <= 1'b0;
			o_idx_q  <= '0;
			o_cd_q   <= '0;
			o_idd_q  <= '0;
			o_rk_q   <= '0;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tuser  = o_mark_q;
	assign m_tlast  = o_mark_q;
	assign m_tdata  = {4'd0, o_rk_q, o_idd_q, o_cd_q, o_idx_q, o_row_q};

endmodule

`default_nettype wire
